// ----- hdl/sus_pkg.sv -----
package sus_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DUP     = 2'd1,
    STATUS_MISSING = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;  // latch compare flags against the broadcast key
    logic ins;  // open a gap at the insert point and drop the key in
    logic rem;  // close the gap at the matching entry
  } cell_ctrl_t;

endpackage

// ----- hdl/sorted_unique_key_set.sv -----
// Ordered set of up to CAPACITY unique keys held in a row of cells, smallest
// key in cell 0. Each item inserts, removes or looks up one key and yields one
// result item with the outcome and the number of keys held afterwards. An item
// passes through a compare state, in which every cell compares its entry with
// the key, and an update state, in which the row shifts by one place (insert or
// remove) and the result is registered. The next item is accepted in the update
// state, so a new item can enter while the last one finishes, as long as
// results are taken; the row stalls in its update state while the previous result
// is still unread. No clearing pass is needed after reset.
module sorted_unique_key_set #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [31:0] result_key,
  output logic [1:0]  status,
  output logic [6:0]  entry_count
);
  import sus_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [1:0]           op_reg;
  logic [KEY_WIDTH-1:0] key_reg;
  logic [63:0]          key_wide;
  logic [63:0]          rk_wide;
  logic [CW+6:0]        cnt_wide;

  logic [KEY_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]  lt_vec;
  logic [CAPACITY-1:0]  eq_vec;
  logic [CAPACITY-1:0]  occ;
  cell_ctrl_t           ctrl;

  logic                 accept;
  logic                 upd_go;
  logic                 hit;
  logic                 full;
  logic                 res_ok;
  status_t              res_status;

  assign key_wide = 64'(key);
  assign rk_wide  = 64'(key_reg);

  assign upd_go   = (state == S_UPD) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || upd_go;
  assign accept   = in_valid && in_ready;

  assign hit  = |eq_vec;
  assign full = (count == CW'(CAPACITY));

  always_comb begin
    res_ok     = 1'b0;
    res_status = STATUS_MISSING;
    unique case (op_reg)
      OP_INSERT: begin
        if (hit) begin
          res_status = STATUS_DUP;
        end else if (full) begin
          res_status = STATUS_FULL;
        end else begin
          res_ok     = 1'b1;
          res_status = STATUS_OK;
        end
      end
      OP_REMOVE, OP_LOOKUP: begin
        if (hit) begin
          res_ok     = 1'b1;
          res_status = STATUS_OK;
        end
      end
      default: begin
        res_ok     = 1'b0;
        res_status = STATUS_MISSING;
      end
    endcase
  end

  always_comb begin
    ctrl.cmp = (state == S_CMP);
    ctrl.ins = upd_go && res_ok && (op_reg == OP_INSERT);
    ctrl.rem = upd_go && res_ok && (op_reg == OP_REMOVE);
  end

  always_comb begin
    priority if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  assign cnt_wide = (CW + 7)'(count_next);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD: begin
        if (upd_go) state_next = in_valid ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg  <= operation;
      key_reg <= key_wide[KEY_WIDTH-1:0];
    end
    if (upd_go) begin
      success     <= res_ok;
      result_key  <= res_ok ? rk_wide[31:0] : 32'd0;
      status      <= res_status;
      entry_count <= cnt_wide[6:0];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_entry;
    logic [KEY_WIDTH-1:0] right_entry;
    logic                 left_lt;

    assign occ[i] = (count > CW'(i));

    if (i == 0) begin : g_first
      assign left_entry = key_reg;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sus_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (key_reg),
      .occupied   (occ[i]),
      .left_entry (left_entry),
      .left_lt    (left_lt),
      .right_entry(right_entry),
      .entry      (entries[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_count_moves_on_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> $past(upd_go))
    else $error("held count changed outside an update");
`endif

endmodule

// ----- hdl/sus_cell.sv -----
module sus_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                  clk,
  input  sus_pkg::cell_ctrl_t   ctrl,
  input  logic [KEY_WIDTH-1:0]  key,
  input  logic                  occupied,
  input  logic [KEY_WIDTH-1:0]  left_entry,
  input  logic                  left_lt,
  input  logic [KEY_WIDTH-1:0]  right_entry,
  output logic [KEY_WIDTH-1:0]  entry,
  output logic                  lt,
  output logic                  eq
);
  import sus_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= occupied && (entry < key);
      eq <= occupied && (entry == key);
    end
  end

  // Cells below the insert/remove point keep their entry; the rest shift.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      entry <= left_lt ? key : left_entry;
    end else if (ctrl.rem && !lt) begin
      entry <= right_entry;
    end
  end

endmodule
